// ===== hdl/demof_pkg.sv =====
package demof_pkg;

	localparam int MM_W      = 12;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam int WINDOW_DEPTH_DEF = 8;

	localparam logic [MM_W-1:0] MIN_VALID_DEF   = MM_W'(250);
	localparam logic [MM_W-1:0] INVALID_DEF     = MM_W'(2550);
	localparam logic [MM_W-1:0] FRONT_LIMIT_DEF = MM_W'(500);
	localparam logic [MM_W-1:0] MIN_BLOCKED_DEF = MM_W'(300);

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INVALID     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIMIT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCKED = CFG_IDX_W'(3);

	typedef struct packed {
		logic capture;
		logic offer;
		logic cnt_clr;
		logic cand_load;
		logic cmp_en;
		logic judge;
		logic front_calc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== hdl/demof_lane.sv =====
module demof_lane #(
	parameter int DEPTH = demof_pkg::WINDOW_DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  demof_pkg::cmd_t            cmd,
	input  logic [demof_pkg::MM_W-1:0] echo,
	input  logic [demof_pkg::MM_W-1:0] min_valid,
	input  logic [demof_pkg::MM_W-1:0] invalid,
	input  logic [IDX_W-1:0]           rd_addr,
	input  logic [CNT_W-1:0]           cmp_idx,
	input  logic [CNT_W-1:0]           cand_idx,
	output logic [CNT_W-1:0]           fill,
	output logic [demof_pkg::MM_W-1:0] med_mm
);
	import demof_pkg::*;

	logic [MM_W-1:0]  win_q [DEPTH];
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] slot_q;
	logic [MM_W-1:0]  last_q;
	logic [MM_W-1:0]  rdata_q;
	logic [MM_W-1:0]  cand_q;
	logic [MM_W-1:0]  med_q;
	logic [CNT_W-1:0] lt_q;
	logic [CNT_W-1:0] le_q;
	logic [CNT_W-1:0] half;
	logic             take;
	logic             elem_ok;

	// an echo repeating the last stored value is dropped
	assign take = cmd.offer && (echo >= min_valid) && (echo < invalid)
		&& !((fill_q != '0) && (last_q == echo));
	assign half    = fill_q >> 1;
	assign elem_ok = cmd.cmp_en && (cmp_idx < fill_q);

	always_ff @(posedge clk) begin
		if (take) begin
			win_q[slot_q] <= echo;
		end
		rdata_q <= win_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			slot_q <= '0;
		end else if (take) begin
			slot_q <= (slot_q == IDX_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (fill_q != CNT_W'(DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// rank counting: candidate is the median when lt <= fill/2 < le
	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= echo;
		end
		if (cmd.cand_load) begin
			cand_q <= rdata_q;
		end
		if (cmd.cnt_clr) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (elem_ok) begin
			if (rdata_q < cand_q) begin
				lt_q <= lt_q + 1'b1;
			end
			if (rdata_q <= cand_q) begin
				le_q <= le_q + 1'b1;
			end
		end
		if (cmd.judge && (cand_idx < fill_q) && (lt_q <= half) && (half < le_q)) begin
			med_q <= cand_q;
		end
	end

	assign fill   = fill_q;
	assign med_mm = (fill_q == '0) ? invalid : med_q;

endmodule

// ===== hdl/demof_datapath.sv =====
module demof_datapath #(
	parameter int DEPTH = demof_pkg::WINDOW_DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  demof_pkg::cmd_t                 cmd,
	output demof_pkg::status_t              status,
	input  logic [IDX_W-1:0]                rd_addr,
	input  logic [CNT_W-1:0]                cmp_idx,
	input  logic [CNT_W-1:0]                cand_idx,
	output logic [CNT_W-1:0]                nmax,
	input  logic                            cfg_we,
	input  logic [demof_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [demof_pkg::MM_W-1:0]      cfg_val,
	input  logic [demof_pkg::MM_W-1:0]      left_echo_mm,
	input  logic [demof_pkg::MM_W-1:0]      right_echo_mm,
	input  logic [demof_pkg::TIME_W-1:0]    now_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [demof_pkg::MM_W-1:0]      left_distance_mm,
	output logic [demof_pkg::MM_W-1:0]      right_distance_mm,
	output logic [demof_pkg::MM_W-1:0]      front_distance_mm,
	output logic                            blocked,
	output logic [demof_pkg::TIME_W-1:0]    blocked_time_ms
);
	import demof_pkg::*;

	logic [MM_W-1:0]   min_valid_q;
	logic [MM_W-1:0]   invalid_q;
	logic [MM_W-1:0]   front_limit_q;
	logic [MM_W-1:0]   min_blocked_q;
	logic [MM_W-1:0]   left_q;
	logic [MM_W-1:0]   right_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  left_fill;
	logic [CNT_W-1:0]  right_fill;
	logic [MM_W-1:0]   left_dist;
	logic [MM_W-1:0]   right_dist;
	logic [MM_W-1:0]   front_q;
	logic              was_blocked_q;
	logic [TIME_W-1:0] start_q;
	logic              out_valid_q;
	logic [MM_W-1:0]   out_left_q;
	logic [MM_W-1:0]   out_right_q;
	logic [MM_W-1:0]   out_front_q;
	logic              out_blk_q;
	logic [TIME_W-1:0] out_time_q;
	logic              blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q   <= MIN_VALID_DEF;
			invalid_q     <= INVALID_DEF;
			front_limit_q <= FRONT_LIMIT_DEF;
			min_blocked_q <= MIN_BLOCKED_DEF;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_VALID:   min_valid_q   <= cfg_val;
				REG_INVALID:     invalid_q     <= cfg_val;
				REG_FRONT_LIMIT: front_limit_q <= cfg_val;
				REG_MIN_BLOCKED: min_blocked_q <= cfg_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			left_q  <= left_echo_mm;
			right_q <= right_echo_mm;
			now_q   <= now_ms;
		end
	end

	demof_lane #(.DEPTH(DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.echo     (left_q),
		.min_valid(min_valid_q),
		.invalid  (invalid_q),
		.rd_addr  (rd_addr),
		.cmp_idx  (cmp_idx),
		.cand_idx (cand_idx),
		.fill     (left_fill),
		.med_mm   (left_dist)
	);

	demof_lane #(.DEPTH(DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.echo     (right_q),
		.min_valid(min_valid_q),
		.invalid  (invalid_q),
		.rd_addr  (rd_addr),
		.cmp_idx  (cmp_idx),
		.cand_idx (cand_idx),
		.fill     (right_fill),
		.med_mm   (right_dist)
	);

	assign nmax = (left_fill > right_fill) ? left_fill : right_fill;

	always_ff @(posedge clk) begin
		if (cmd.front_calc) begin
			if ((left_dist <= front_limit_q) || (right_dist <= front_limit_q)) begin
				front_q <= (left_dist < right_dist) ? left_dist : right_dist;
			end else begin
				front_q <= invalid_q;
			end
		end
	end

	assign blk = front_q < min_blocked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_blocked_q <= 1'b0;
			start_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				was_blocked_q <= blk;
				if (blk && !was_blocked_q) begin
					start_q <= now_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_left_q  <= left_dist;
			out_right_q <= right_dist;
			out_front_q <= front_q;
			out_blk_q   <= blk;
			out_time_q  <= (blk && was_blocked_q) ? now_q - start_q : '0;
		end
	end

	assign status.out_free   = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign left_distance_mm  = out_left_q;
	assign right_distance_mm = out_right_q;
	assign front_distance_mm = out_front_q;
	assign blocked           = out_blk_q;
	assign blocked_time_ms   = out_time_q;

endmodule

// ===== hdl/demof_ctrl.sv =====
module demof_ctrl #(
	parameter int DEPTH = demof_pkg::WINDOW_DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  demof_pkg::status_t status,
	input  logic [CNT_W-1:0]   nmax,
	output demof_pkg::cmd_t    cmd,
	output logic [IDX_W-1:0]   rd_addr,
	output logic [CNT_W-1:0]   cmp_idx,
	output logic [CNT_W-1:0]   cand_idx
);
	import demof_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OFFER,
		S_START,
		S_CAND,
		S_SWEEP,
		S_TAIL,
		S_JUDGE,
		S_FRONT,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] last_idx;

	assign last_idx = nmax - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_OFFER;
					end
				end
				S_OFFER: state_q <= S_START;
				S_START: begin
					i_q     <= '0;
					state_q <= (nmax == '0) ? S_FRONT : S_CAND;
				end
				S_CAND: begin
					j_q     <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					j_q <= j_q + 1'b1;
					if (j_q == last_idx) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: state_q <= S_JUDGE;
				S_JUDGE: begin
					if (i_q == last_idx) begin
						state_q <= S_FRONT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CAND;
					end
				end
				S_FRONT: state_q <= S_OUT;
				S_OUT: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		rd_addr  = j_q[IDX_W-1:0];
		cmp_idx  = j_q - 1'b1;
		cand_idx = i_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_OFFER: cmd.offer = 1'b1;
			S_CAND: begin
				rd_addr     = i_q[IDX_W-1:0];
				cmd.cnt_clr = 1'b1;
			end
			S_SWEEP: begin
				// first sweep cycle brings the candidate back from the window
				cmd.cand_load = (j_q == '0);
				cmd.cmp_en    = (j_q != '0);
			end
			S_TAIL:  cmd.cmp_en     = 1'b1;
			S_JUDGE: cmd.judge      = 1'b1;
			S_FRONT: cmd.front_calc = 1'b1;
			S_OUT:   cmd.out_load   = status.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hdl/dual_echo_median_obstacle_filter.sv =====
// dual echo median obstacle filter
// s_axis carries one frame request: left and right echo distances in mm and
// the frame time in ms. m_axis returns one result per frame: both side
// medians, the front distance, the blocked flag and the blocked time.
// the cfg channel writes the four threshold registers (0 min valid, 1 invalid
// mark, 2 front limit, 3 blocking threshold); cfg_ready is always high and
// writes are meant to happen only while no frame is in flight.
// the time from acceptance to m_axis_tvalid grows with n, the larger fill of
// the two windows after the new echoes are stored (up to WINDOW_DEPTH). one
// frame is in work at a time, so a new frame is taken only after the last
// one has left its final step: the median is found by rank counting, one
// window entry per cycle through each side's single read port.
// reset empties both windows, clears the blocked timer, drops m_axis_tvalid
// and restores the register defaults. a result held while m_axis_tready is
// low does not stop the next frame being accepted; that frame waits in its
// final step until the output register is free.
module dual_echo_median_obstacle_filter #(
	parameter int WINDOW_DEPTH = demof_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// left_echo_mm [11:0], right_echo_mm [23:12], now_ms [55:24]
	input  logic [55:0]                     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// left_distance_mm [11:0], right_distance_mm [23:12],
	// front_distance_mm [35:24], blocked [36], blocked_time_ms [68:37], zero [71:69]
	output logic [71:0]                     m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [demof_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [demof_pkg::MM_W-1:0]      cfg_data
);
	import demof_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

	cmd_t              cmd;
	status_t           status;
	logic [IDX_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  cmp_idx;
	logic [CNT_W-1:0]  cand_idx;
	logic [CNT_W-1:0]  nmax;
	logic [MM_W-1:0]   left_dist;
	logic [MM_W-1:0]   right_dist;
	logic [MM_W-1:0]   front_dist;
	logic              blk;
	logic [TIME_W-1:0] blk_time;

	assign cfg_ready = 1'b1;

	demof_ctrl #(.DEPTH(WINDOW_DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.nmax    (nmax),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.cmp_idx (cmp_idx),
		.cand_idx(cand_idx)
	);

	demof_datapath #(.DEPTH(WINDOW_DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.rd_addr          (rd_addr),
		.cmp_idx          (cmp_idx),
		.cand_idx         (cand_idx),
		.nmax             (nmax),
		.cfg_we           (cfg_valid),
		.cfg_idx          (cfg_index),
		.cfg_val          (cfg_data),
		.left_echo_mm     (s_axis_tdata[11:0]),
		.right_echo_mm    (s_axis_tdata[23:12]),
		.now_ms           (s_axis_tdata[55:24]),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.left_distance_mm (left_dist),
		.right_distance_mm(right_dist),
		.front_distance_mm(front_dist),
		.blocked          (blk),
		.blocked_time_ms  (blk_time)
	);

	assign m_axis_tdata = {3'b000, blk_time, blk, front_dist, right_dist, left_dist};

endmodule

// ===== hdl/demof_checker.sv =====
module demof_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [71:0]                     m_axis_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [demof_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [demof_pkg::MM_W-1:0]      cfg_data
);
	import demof_pkg::*;

	logic [MM_W-1:0] invalid_q;
	logic            in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// shadow of the invalid mark as written through the cfg port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_q <= INVALID_DEF;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_INVALID)) begin
			invalid_q <= cfg_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second frame taken while one is in work");

	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[36] |-> (m_axis_tdata[68:37] == '0))
		else $error("blocked time not zero while unblocked");

	a_front_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[35:24] == m_axis_tdata[11:0])
			|| (m_axis_tdata[35:24] == m_axis_tdata[23:12])
			|| (m_axis_tdata[35:24] == invalid_q))
		else $error("front distance matches neither side nor invalid mark");

endmodule

bind dual_echo_median_obstacle_filter demof_checker u_demof_checker (.*);

// ===== verif/tb.sv =====
module tb;
	import demof_pkg::*;

	localparam int WIN_DEPTH       = WINDOW_DEPTH_DEF;
	localparam int N_PHASES        = 7;
	localparam int PHASE_FRAMES    = 250;
	localparam int N_PROBES        = 20;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int SETTLE_CYCLES   = 100;
	localparam int MAX_PRINTED     = 40;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [MM_W-1:0]   right_mm;
		logic [MM_W-1:0]   left_mm;
	} frame_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] blocked_ms;
		logic              blocked;
		logic [MM_W-1:0]   front_mm;
		logic [MM_W-1:0]   right_mm;
		logic [MM_W-1:0]   left_mm;
	} frame_result_t;

	typedef struct {
		logic [MM_W-1:0]   left_mm;
		logic [MM_W-1:0]   right_mm;
		logic [TIME_W-1:0] now_ms;
		bit                typed;
		logic [MM_W-1:0]   exp_left;
		logic [MM_W-1:0]   exp_right;
		logic [MM_W-1:0]   exp_front;
		logic              exp_blocked;
		logic [TIME_W-1:0] exp_blocked_ms;
	} probe_row_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_TRICKLE} rx_pattern_t;

	localparam int SIDE_LEFT  = 0;
	localparam int SIDE_RIGHT = 1;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [55:0]          s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [71:0]          m_axis_tdata;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [MM_W-1:0]      cfg_data      = '0;

	dual_echo_median_obstacle_filter #(
		.WINDOW_DEPTH(WIN_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// shadow of the filter: thresholds, echo windows and blocked timer
	logic [MM_W-1:0]   min_valid_r   = MIN_VALID_DEF;
	logic [MM_W-1:0]   invalid_r     = INVALID_DEF;
	logic [MM_W-1:0]   front_limit_r = FRONT_LIMIT_DEF;
	logic [MM_W-1:0]   min_blocked_r = MIN_BLOCKED_DEF;
	logic [MM_W-1:0]   win_mm [2][WIN_DEPTH];
	int unsigned       fill_cnt [2] = '{0, 0};
	int unsigned       wr_slot [2]  = '{0, 0};
	logic              blk_prev     = 1'b0;
	logic [TIME_W-1:0] blk_start    = '0;

	frame_result_t pending_results [$];
	int            err_cnt      = 0;
	int            results_seen = 0;
	int            idle_cycles  = 0;
	int            burst_left   = 0;

	rx_pattern_t     rx_pattern = RX_OPEN;
	int unsigned     rx_hold    = 0;
	logic [7:0]      rx_tick    = '0;

	logic [MM_W-1:0]   scene_mm [2];
	logic [MM_W-1:0]   last_tx [2] = '{'0, '0};
	logic [TIME_W-1:0] frame_now   = '0;
	logic [MM_W-1:0]   phase_cfg [N_PHASES][4];
	probe_row_t        probe_rows [N_PROBES];
	frame_result_t     got_res;
	frame_result_t     want_res;
	frame_req_t        req;
	frame_result_t     typed_res;

	function automatic void store_echo(int side, logic [MM_W-1:0] echo);
		int unsigned prev;
		if (echo < min_valid_r || echo >= invalid_r)
			return;
		// a repeat of the newest stored echo is dropped
		if (fill_cnt[side] > 0) begin
			prev = (wr_slot[side] == 0) ? WIN_DEPTH - 1 : wr_slot[side] - 1;
			if (win_mm[side][prev] == echo)
				return;
		end
		win_mm[side][wr_slot[side]] = echo;
		wr_slot[side] = (wr_slot[side] + 1) % WIN_DEPTH;
		if (fill_cnt[side] < WIN_DEPTH)
			fill_cnt[side]++;
	endfunction

	function automatic logic [MM_W-1:0] side_median(int side);
		logic [MM_W-1:0] srt [WIN_DEPTH];
		logic [MM_W-1:0] v;
		int n, i, j;
		n = fill_cnt[side];
		if (n == 0)
			return invalid_r;
		for (i = 0; i < n; i++)
			srt[i] = win_mm[side][i];
		for (i = 1; i < n; i++) begin
			v = srt[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		// even count takes the upper middle entry
		return srt[n/2];
	endfunction

	function automatic frame_result_t predict_frame(frame_req_t rq);
		frame_result_t r;
		store_echo(SIDE_RIGHT, rq.right_mm);
		store_echo(SIDE_LEFT, rq.left_mm);
		r.left_mm  = side_median(SIDE_LEFT);
		r.right_mm = side_median(SIDE_RIGHT);
		if (r.left_mm <= front_limit_r || r.right_mm <= front_limit_r)
			r.front_mm = (r.left_mm < r.right_mm) ? r.left_mm : r.right_mm;
		else
			r.front_mm = invalid_r;
		r.blocked = r.front_mm < min_blocked_r;
		if (r.blocked) begin
			if (!blk_prev)
				blk_start = rq.now_ms;
			blk_prev     = 1'b1;
			r.blocked_ms = rq.now_ms - blk_start;
		end else begin
			blk_prev     = 1'b0;
			r.blocked_ms = '0;
		end
		return r;
	endfunction

	function automatic logic [MM_W-1:0] pick_scene();
		int lo, hi;
		lo = min_valid_r;
		hi = int'(invalid_r) - 1;
		if (hi < lo)
			return MM_W'($urandom_range(0, 4095));
		// half the scenes sit close to the lower bound so blocking shows up
		if ($urandom_range(0, 1) == 1 && lo + 300 < hi)
			hi = lo + 300;
		return MM_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [MM_W-1:0] pick_echo(int side);
		int v, r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			v = int'(scene_mm[side]) + int'($urandom_range(0, 16)) - 8;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return MM_W'(v);
		end
		if (r < 70)
			return last_tx[side];
		if (r < 85)
			return MM_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return min_valid_r;
			3: return min_valid_r - 1'b1;
			4: return invalid_r;
			5: return invalid_r - 1'b1;
			6: return front_limit_r;
			default: return min_blocked_r;
		endcase
	endfunction

	task automatic report_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// entered and left at a falling edge; tvalid stays high into the next request
	task automatic send_frame(input frame_req_t rq, input bit typed,
			input frame_result_t typed_r);
		int gap;
		frame_result_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rq;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		// the shadow windows follow every request, typed or not
		pred = predict_frame(rq);
		pending_results.push_back(typed ? typed_r : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_MIN_VALID:   min_valid_r   = val;
			REG_INVALID:     invalid_r     = val;
			REG_FRONT_LIMIT: front_limit_r = val;
			REG_MIN_BLOCKED: min_blocked_r = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// receiver readiness follows one pattern for a while, then picks another
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (rx_hold == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(RX_OPEN, RX_TRICKLE));
			rx_hold    <= $urandom_range(16, 256);
		end else begin
			rx_hold <= rx_hold - 1;
		end
		case (rx_pattern)
			RX_OPEN:    m_axis_tready <= 1'b1;
			RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			RX_QUARTER: m_axis_tready <= (rx_tick[1:0] == 2'd0);
			default:    m_axis_tready <= (rx_tick[5:0] == 6'd0);
		endcase
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_res = m_axis_tdata[68:0];
			results_seen++;
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with no request pending",
					results_seen));
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.left_mm != want_res.left_mm)
					report_error($sformatf("result %0d left_distance_mm %0d, want %0d",
						results_seen, got_res.left_mm, want_res.left_mm));
				if (got_res.right_mm != want_res.right_mm)
					report_error($sformatf("result %0d right_distance_mm %0d, want %0d",
						results_seen, got_res.right_mm, want_res.right_mm));
				if (got_res.front_mm != want_res.front_mm)
					report_error($sformatf("result %0d front_distance_mm %0d, want %0d",
						results_seen, got_res.front_mm, want_res.front_mm));
				if (got_res.blocked != want_res.blocked)
					report_error($sformatf("result %0d blocked %0b, want %0b",
						results_seen, got_res.blocked, want_res.blocked));
				if (got_res.blocked_ms != want_res.blocked_ms)
					report_error($sformatf("result %0d blocked_time_ms %0d, want %0d",
						results_seen, got_res.blocked_ms, want_res.blocked_ms));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// min valid, invalid mark, front limit, blocking threshold
		phase_cfg = '{
			'{12'd250,  12'd2550, 12'd500,  12'd300},
			'{12'd0,    12'd4095, 12'd4095, 12'd4095},
			'{12'd0,    12'd0,    12'd0,    12'd0},
			'{12'd4095, 12'd4095, 12'd0,    12'd0},
			'{12'd1000, 12'd500,  12'd200,  12'd800},
			'{12'd100,  12'd3000, 12'd1500, 12'd700},
			'{12'd300,  12'd1200, 12'd4095, 12'd1000}
		};
		// left, right, now, typed, then left, right, front, blocked, blocked time
		probe_rows = '{
			'{12'd0,    12'd4095, 32'd0,  1'b1, 12'd2550, 12'd2550, 12'd2550, 1'b0, 32'd0},
			'{12'd250,  12'd2549, 32'd10, 1'b1, 12'd250,  12'd2549, 12'd250,  1'b1, 32'd0},
			'{12'd250,  12'd2550, 32'd25, 1'b1, 12'd250,  12'd2549, 12'd250,  1'b1, 32'd15},
			'{12'd249,  12'd400,  32'd40, 1'b1, 12'd250,  12'd2549, 12'd250,  1'b1, 32'd30},
			'{12'd280,  12'd400,  32'd50, 1'b1, 12'd280,  12'd2549, 12'd280,  1'b1, 32'd40},
			'{12'd600,  12'd350,  32'd60, 1'b1, 12'd280,  12'd400,  12'd280,  1'b1, 32'd50},
			'{12'd700,  12'd800,  32'd70, 1'b1, 12'd600,  12'd800,  12'd2550, 1'b0, 32'd0},
			'{12'd900,  12'd1000, 32'd80,           1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd1100, 12'd1200, 32'd90,           1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd1300, 12'd1400, 32'd100,          1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd1500, 12'd1600, 32'd110,          1'b0, '0, '0, '0, 1'b0, '0},
			// windows full from here, oldest entries get replaced
			'{12'd260,  12'd270,  32'd120,          1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd270,  12'd260,  32'd130,          1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd260,  12'd270,  32'd140,          1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd270,  12'd260,  32'd150,          1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd260,  12'd270,  32'hFFFF_FFF0,    1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd270,  12'd260,  32'hFFFF_FFFF,    1'b0, '0, '0, '0, 1'b0, '0},
			// timer keeps counting across the wrap
			'{12'd260,  12'd270,  32'h0000_0010,    1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd4095, 12'd0,    32'hFFFF_FFFF,    1'b0, '0, '0, '0, 1'b0, '0},
			'{12'd2000, 12'd2000, 32'hAAAA_5555,    1'b0, '0, '0, '0, 1'b0, '0}
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probe_rows[k]) begin
			req.left_mm          = probe_rows[k].left_mm;
			req.right_mm         = probe_rows[k].right_mm;
			req.now_ms           = probe_rows[k].now_ms;
			typed_res.left_mm    = probe_rows[k].exp_left;
			typed_res.right_mm   = probe_rows[k].exp_right;
			typed_res.front_mm   = probe_rows[k].exp_front;
			typed_res.blocked    = probe_rows[k].exp_blocked;
			typed_res.blocked_ms = probe_rows[k].exp_blocked_ms;
			send_frame(req, probe_rows[k].typed, typed_res);
		end
		frame_now = 32'hAAAA_5555;
		last_tx   = '{12'd2000, 12'd2000};

		for (int p = 0; p < N_PHASES; p++) begin
			// thresholds change only with no request in flight
			s_axis_tvalid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
			@(negedge clk);
			write_reg(REG_MIN_VALID,   phase_cfg[p][0]);
			write_reg(REG_INVALID,     phase_cfg[p][1]);
			write_reg(REG_FRONT_LIMIT, phase_cfg[p][2]);
			write_reg(REG_MIN_BLOCKED, phase_cfg[p][3]);
			// indexes past the register list must be ignored
			write_reg(REG_MIN_BLOCKED + CFG_IDX_W'($urandom_range(1, 4)),
				MM_W'($urandom_range(0, 4095)));
			cfg_valid <= 1'b0;
			scene_mm = '{pick_scene(), pick_scene()};

			for (int n = 0; n < PHASE_FRAMES; n++) begin
				if ($urandom_range(0, 15) == 0)
					scene_mm[SIDE_LEFT] = pick_scene();
				if ($urandom_range(0, 15) == 0)
					scene_mm[SIDE_RIGHT] = pick_scene();
				case ($urandom_range(0, 99))
					0, 1, 2: frame_now = $urandom();
					3:       frame_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
					default: frame_now = frame_now + $urandom_range(1, 120);
				endcase
				req.left_mm         = pick_echo(SIDE_LEFT);
				req.right_mm        = pick_echo(SIDE_RIGHT);
				req.now_ms          = frame_now;
				last_tx[SIDE_LEFT]  = req.left_mm;
				last_tx[SIDE_RIGHT] = req.right_mm;
				send_frame(req, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/demof_pkg.sv
hdl/demof_lane.sv
hdl/demof_datapath.sv
hdl/demof_ctrl.sv
hdl/dual_echo_median_obstacle_filter.sv
hdl/demof_checker.sv
verif/tb.sv
